// ===== src/kbrb_pkg.sv =====
// Package for the keyboard report builder: request and status codes,
// controller states, command and status structs, and the character ROM.
// Depends on nothing; the datapath, controller and top level import it.
package kbrb_pkg;

   // Number of key usage slots in a boot keyboard report.
   localparam int unsigned NUM_SLOTS = 6;

   // Key code bases: raw usages start at RAW_BASE, modifier bits at MOD_BASE.
   localparam logic [7:0] RAW_BASE    = 8'd136;
   localparam logic [7:0] MOD_BASE    = 8'd128;
   localparam logic [7:0] ASCII_SPACE = 8'd32;

   // Flag bits carried above the usage byte in a ROM entry.
   localparam int unsigned FLAG_SHIFT = 8;
   localparam int unsigned FLAG_ALTGR = 9;
   localparam int unsigned FLAG_DEAD  = 10;

   // Modifier bits that the ROM flags turn on.
   localparam logic [7:0] MOD_LSHIFT = 8'h02;
   localparam logic [7:0] MOD_RALT   = 8'h40;

   // Request kinds carried in req_type.
   typedef enum logic [1:0] {
      REQ_PRESS       = 2'd0,
      REQ_RELEASE     = 2'd1,
      REQ_RELEASE_ALL = 2'd2,
      REQ_IGNORED     = 2'd3
   } req_kind_type;

   // Status codes of a result item.
   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_UNMAPPED = 2'd1,
      STATUS_FULL     = 2'd2
   } status_type;

   // Which operation the datapath carries out in an execute cycle.
   typedef enum logic [1:0] {
      EXEC_MAIN,
      EXEC_SPACE_PRESS,
      EXEC_SPACE_RELEASE
   } exec_sel_type;

   // Controller states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MAIN,
      ST_EMIT_MAIN,
      ST_SPACE_DN,
      ST_EMIT_DN,
      ST_SPACE_UP,
      ST_EMIT_UP
   } ctrl_state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic         capture;
      logic         exec;
      exec_sel_type exec_sel;
      logic         last;
   } dp_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic last;
   } dp_sts_type;

   // Character ROM for codes 32 to 126, both layout columns.
   function automatic logic [10:0] char_rom(input logic [6:0] idx, input logic col);
      logic [21:0] pair;
      case (idx) inside
         7'd0:  pair = {11'h02c, 11'h02c};
         7'd1:  pair = {11'h11e, 11'h11e};
         7'd2:  pair = {11'h11f, 11'h134};
         7'd3:  pair = {11'h220, 11'h120};
         7'd4:  pair = {11'h121, 11'h121};
         7'd5:  pair = {11'h122, 11'h122};
         7'd6:  pair = {11'h123, 11'h124};
         7'd7:  pair = {11'h02d, 11'h034};
         7'd8:  pair = {11'h125, 11'h126};
         7'd9:  pair = {11'h126, 11'h127};
         7'd10: pair = {11'h130, 11'h125};
         7'd11: pair = {11'h030, 11'h12e};
         7'd12: pair = {11'h036, 11'h036};
         7'd13: pair = {11'h038, 11'h02d};
         7'd14: pair = {11'h037, 11'h037};
         7'd15: pair = {11'h124, 11'h038};
         7'd16: pair = {11'h027, 11'h027};
         7'd17: pair = {11'h01e, 11'h01e};
         7'd18: pair = {11'h01f, 11'h01f};
         7'd19: pair = {11'h020, 11'h020};
         7'd20: pair = {11'h021, 11'h021};
         7'd21: pair = {11'h022, 11'h022};
         7'd22: pair = {11'h023, 11'h023};
         7'd23: pair = {11'h024, 11'h024};
         7'd24: pair = {11'h025, 11'h025};
         7'd25: pair = {11'h026, 11'h026};
         7'd26: pair = {11'h137, 11'h133};
         7'd27: pair = {11'h136, 11'h033};
         7'd28: pair = {11'h064, 11'h136};
         7'd29: pair = {11'h127, 11'h02e};
         7'd30: pair = {11'h164, 11'h137};
         7'd31: pair = {11'h12d, 11'h138};
         7'd32: pair = {11'h21f, 11'h11f};
         // Upper-case letters: shifted usages 0x04 to 0x1d in both layouts.
         [7'd33:7'd58]: pair = {11'h100 | {4'd0, idx - 7'd29},
                                11'h100 | {4'd0, idx - 7'd29}};
         7'd59: pair = {11'h22f, 11'h02f};
         7'd60: pair = {11'h235, 11'h031};
         7'd61: pair = {11'h230, 11'h030};
         7'd62: pair = {11'h52f, 11'h123};
         7'd63: pair = {11'h138, 11'h12d};
         7'd64: pair = {11'h42f, 11'h035};
         // Lower-case letters: plain usages 0x04 to 0x1d in both layouts.
         [7'd65:7'd90]: pair = {{4'd0, idx - 7'd61}, {4'd0, idx - 7'd61}};
         7'd91: pair = {11'h234, 11'h12f};
         7'd92: pair = {11'h21e, 11'h131};
         7'd93: pair = {11'h231, 11'h130};
         7'd94: pair = {11'h221, 11'h135};
         default: pair = 22'd0;
      endcase
      return col ? pair[21:11] : pair[10:0];
   endfunction

   // Full lookup of an ASCII code; zero means the character has no mapping.
   function automatic logic [10:0] rom_lookup(input logic [7:0] code, input logic col);
      logic [10:0] k;
      case (code) inside
         [8'd128:8'd255]: k = 11'd0;
         8'd8:            k = 11'h02a;
         8'd9:            k = 11'h02b;
         8'd10:           k = 11'h028;
         [8'd0:8'd31]:    k = 11'd0;
         default:         k = char_rom(7'(code - ASCII_SPACE), col);
      endcase
      return k;
   endfunction

endpackage

// ===== src/kbrb_if.sv =====
// Handshake channels of the keyboard report builder: the request channel
// and the report channel, each with valid, ready and payload.
// Depends on nothing.
interface kbrb_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] req_type;
   logic [7:0] key_code;

   modport source (output valid, output req_type, output key_code, input ready);
   modport sink (input valid, input req_type, input key_code, output ready);
endinterface

interface kbrb_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] modifiers;
   logic [7:0] key_slot_0;
   logic [7:0] key_slot_1;
   logic [7:0] key_slot_2;
   logic [7:0] key_slot_3;
   logic [7:0] key_slot_4;
   logic [7:0] key_slot_5;
   logic       report_sent;
   logic [1:0] status;
   logic       last;

   modport source (output valid, output modifiers, output key_slot_0,
                   output key_slot_1, output key_slot_2, output key_slot_3,
                   output key_slot_4, output key_slot_5, output report_sent,
                   output status, output last, input ready);
   modport sink (input valid, input modifiers, input key_slot_0,
                 input key_slot_1, input key_slot_2, input key_slot_3,
                 input key_slot_4, input key_slot_5, input report_sent,
                 input status, input last, output ready);
endinterface

// ===== src/kbrb_datapath.sv =====
// Datapath of the keyboard report builder: request capture, key slots,
// modifier byte, layout register and the press/release execute unit.
// Depends on kbrb_pkg.
module kbrb_datapath
   import kbrb_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  dp_cmd_type cmd,
   output dp_sts_type sts,
   input  logic       csr_wr_en,
   input  logic       csr_wr_data,
   input  logic [1:0] req_type,
   input  logic [7:0] key_code,
   output logic [7:0] modifiers,
   output logic [7:0] slots [NUM_SLOTS],
   output logic       report_sent,
   output logic [1:0] status,
   output logic       last
);

   logic [1:0] req_type_ff;
   logic [7:0] key_code_ff;
   logic [7:0] slots_ff [NUM_SLOTS];
   logic [7:0] slots_in [NUM_SLOTS];
   logic [7:0] mods_ff, mods_in;
   logic       layout_ff;
   status_type status_ff, status_in;
   logic       sent_ff, sent_in;
   logic       last_ff;
   logic       dead_in;

   // Captured request fields.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_type_ff <= req_type;
         key_code_ff <= key_code;
      end
   end

   // Layout select register.
   always_ff @(posedge clock) begin
      if (reset) begin
         layout_ff <= 1'b0;
      end else if (csr_wr_en) begin
         layout_ff <= csr_wr_data;
      end
   end

   // Execute unit: one press, release or release-all on the current report.
   always_comb begin
      req_kind_type kind;
      logic [7:0]   code;
      logic [10:0]  k;
      logic         mapped;
      logic [7:0]   usage;
      logic [7:0]   mod_mask;
      logic         found;
      logic         placed;

      case (cmd.exec_sel)
         EXEC_SPACE_PRESS: begin
            kind = REQ_PRESS;
            code = ASCII_SPACE;
         end
         EXEC_SPACE_RELEASE: begin
            kind = REQ_RELEASE;
            code = ASCII_SPACE;
         end
         default: begin
            kind = req_kind_type'(req_type_ff);
            code = key_code_ff;
         end
      endcase

      // Decode the key code into a usage and the modifier bits it touches.
      k = rom_lookup(code, layout_ff);
      if (code >= RAW_BASE) begin
         mapped   = 1'b1;
         usage    = code - RAW_BASE;
         mod_mask = 8'd0;
         dead_in  = 1'b0;
      end else if (code >= MOD_BASE) begin
         mapped   = 1'b1;
         usage    = 8'd0;
         mod_mask = 8'd1 << code[2:0];
         dead_in  = 1'b0;
      end else begin
         mapped   = (k != 11'd0);
         usage    = k[7:0];
         mod_mask = (k[FLAG_SHIFT] ? MOD_LSHIFT : 8'd0) | (k[FLAG_ALTGR] ? MOD_RALT : 8'd0);
         dead_in  = k[FLAG_DEAD];
      end

      slots_in  = slots_ff;
      mods_in   = mods_ff;
      status_in = STATUS_OK;
      sent_in   = 1'b1;
      found     = 1'b0;
      placed    = 1'b0;

      case (kind)
         REQ_PRESS: begin
            if (!mapped) begin
               status_in = STATUS_UNMAPPED;
            end else begin
               mods_in = mods_ff | mod_mask;
               for (int i = 0; i < NUM_SLOTS; i++) begin
                  if (slots_ff[i] == usage) found = 1'b1;
               end
               if (!found) begin
                  for (int i = 0; i < NUM_SLOTS; i++) begin
                     if (!placed && slots_ff[i] == 8'd0) begin
                        slots_in[i] = usage;
                        placed      = 1'b1;
                     end
                  end
                  if (!placed) status_in = STATUS_FULL;
               end
            end
         end
         REQ_RELEASE: begin
            if (!mapped) begin
               status_in = STATUS_UNMAPPED;
            end else begin
               mods_in = mods_ff & ~mod_mask;
               for (int i = 0; i < NUM_SLOTS; i++) begin
                  if (usage != 8'd0 && slots_ff[i] == usage) slots_in[i] = 8'd0;
               end
            end
         end
         REQ_RELEASE_ALL: begin
            mods_in = 8'd0;
            for (int i = 0; i < NUM_SLOTS; i++) slots_in[i] = 8'd0;
         end
         default: begin
            sent_in = 1'b0;
         end
      endcase

      if (status_in != STATUS_OK) sent_in = 1'b0;
      // A dead key only counts when its own press went through.
      dead_in = dead_in && (kind == REQ_PRESS) && (status_in == STATUS_OK);
   end

   // Report state, updated once per execute cycle.
   always_ff @(posedge clock) begin
      if (reset) begin
         mods_ff <= 8'd0;
         for (int i = 0; i < NUM_SLOTS; i++) slots_ff[i] <= 8'd0;
      end else if (cmd.exec) begin
         mods_ff  <= mods_in;
         slots_ff <= slots_in;
      end
   end

   // Per-item result fields held until the item is taken. A dead key press
   // is never the last result, since the space press and release follow.
   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         status_ff <= status_in;
         sent_ff   <= sent_in;
         last_ff   <= cmd.last && !dead_in;
      end
   end

   // Status to the controller and the outgoing report.
   assign sts.last     = last_ff;
   assign modifiers    = mods_ff;
   assign slots        = slots_ff;
   assign report_sent  = sent_ff;
   assign status       = status_ff;
   assign last         = last_ff;

endmodule

// ===== src/kbrb_controller.sv =====
// Controller of the keyboard report builder: sequences capture, execute and
// result handshakes, including the extra space press and release of a dead key.
// Depends on kbrb_pkg.
module kbrb_controller
   import kbrb_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output dp_cmd_type cmd,
   input  dp_sts_type sts
);

   ctrl_state_type state_ff, state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_MAIN;
         end
         ST_MAIN: begin
            state_in = ST_EMIT_MAIN;
         end
         ST_EMIT_MAIN: begin
            if (rsp_ready) state_in = sts.last ? ST_IDLE : ST_SPACE_DN;
         end
         ST_SPACE_DN: begin
            state_in = ST_EMIT_DN;
         end
         ST_EMIT_DN: begin
            if (rsp_ready) state_in = ST_SPACE_UP;
         end
         ST_SPACE_UP: begin
            state_in = ST_EMIT_UP;
         end
         ST_EMIT_UP: begin
            if (rsp_ready) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Outputs and datapath commands.
   always_comb begin
      req_ready    = 1'b0;
      rsp_valid    = 1'b0;
      cmd.capture  = 1'b0;
      cmd.exec     = 1'b0;
      cmd.exec_sel = EXEC_MAIN;
      cmd.last     = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = 1'b1;
         end
         ST_MAIN: begin
            cmd.exec = 1'b1;
         end
         ST_SPACE_DN: begin
            cmd.exec     = 1'b1;
            cmd.exec_sel = EXEC_SPACE_PRESS;
            cmd.last     = 1'b0;
         end
         ST_SPACE_UP: begin
            cmd.exec     = 1'b1;
            cmd.exec_sel = EXEC_SPACE_RELEASE;
         end
         ST_EMIT_MAIN, ST_EMIT_DN, ST_EMIT_UP: begin
            rsp_valid = 1'b1;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

endmodule

// ===== src/keyboard_report_builder_core.sv =====
// Top level of the keyboard report builder: controller, datapath and ports.
// Depends on kbrb_pkg, kbrb_if, kbrb_controller and kbrb_datapath.
//
// Keeps a USB HID boot keyboard report (modifier byte and six key slots) and
// answers each press, release or release-all request with one result item,
// or three for a dead key (its own report, a space press, a space release).
// The block works on one request at a time: it accepts a request while idle,
// and each result is computed in the datapath's execute unit and then waits
// on the report channel until taken. The user must write the layout select
// register through csr_wr_en and csr_wr_data only while idle; the block
// itself does not enforce this.
module keyboard_report_builder_core
   import kbrb_pkg::*;
(
   input  logic   clock,
   input  logic   reset,
   kbrb_req_if.sink   req_chan,
   kbrb_rsp_if.source rsp_chan,
   input  logic   csr_wr_en,
   input  logic   csr_wr_data
);

   dp_cmd_type cmd;
   dp_sts_type sts;
   logic [7:0] slots [NUM_SLOTS];

   // Sequencer for capture, execute and handshakes.
   kbrb_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   // Report state and execute unit.
   kbrb_datapath u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .sts         (sts),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_type    (req_chan.req_type),
      .key_code    (req_chan.key_code),
      .modifiers   (rsp_chan.modifiers),
      .slots       (slots),
      .report_sent (rsp_chan.report_sent),
      .status      (rsp_chan.status),
      .last        (rsp_chan.last)
   );

   // Slot array onto the named report fields.
   assign rsp_chan.key_slot_0 = slots[0];
   assign rsp_chan.key_slot_1 = slots[1];
   assign rsp_chan.key_slot_2 = slots[2];
   assign rsp_chan.key_slot_3 = slots[3];
   assign rsp_chan.key_slot_4 = slots[4];
   assign rsp_chan.key_slot_5 = slots[5];

endmodule
